// ===== sv/hva_pkg.sv =====
// ---------------------------------------------------------------------------
// hva_pkg: shared definitions for the homogeneous vector ALU
// Opcodes, status codes, pipeline payload types and Q16.16 rounding helpers.
// ---------------------------------------------------------------------------
package hva_pkg;

  // opcodes
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_NEG     = 4'd2;
  localparam logic [3:0] OP_SCALE   = 4'd3;
  localparam logic [3:0] OP_DIV     = 4'd4;
  localparam logic [3:0] OP_DOT     = 4'd5;
  localparam logic [3:0] OP_CROSS   = 4'd6;
  localparam logic [3:0] OP_MAG     = 4'd7;
  localparam logic [3:0] OP_NORM    = 4'd8;
  localparam logic [3:0] OP_REFLECT = 4'd9;
  localparam logic [3:0] OP_EQ      = 4'd10;
  localparam logic [3:0] OP_ISPOINT = 4'd11;
  localparam logic [3:0] OP_ISVEC   = 4'd12;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // root: one result bit per stage plus a rounding stage; divider: one quotient bit per stage
  localparam int SQ_STEPS  = 33;
  localparam int SQ_LAT    = SQ_STEPS + 1;
  localparam int DIV_STEPS = 48;

  // rounded and saturated Q16.16 value
  typedef struct packed {
    logic [31:0] v;
    logic        ov;
  } rs_t;

  // item context through the front end and the root pipeline
  typedef struct packed {
    logic [3:0]       op;
    logic [3:0][31:0] a;
    logic [31:0]      s;
    logic [3:0][31:0] r;
    logic [31:0]      sc;
    logic             flag;
    logic             ov;
    logic [64:0]      sq;
  } ctx_t;

  // item context through the divider
  typedef struct packed {
    logic [3:0]       op;
    logic [3:0][31:0] r;
    logic [31:0]      sc;
    logic             flag;
    logic             ov;
    logic             dz;
    logic [3:0]       neg;
  } dctx_t;

  // one result item
  typedef struct packed {
    logic [3:0][31:0] r;
    logic [31:0]      sc;
    logic             flag;
    logic [1:0]       status;
  } res_t;

  // exact Q32.32 sum -> nearest Q16.16 (ties up), saturated
  function automatic rs_t round_sat(input logic signed [66:0] p);
    logic signed [66:0] t;
    rs_t o;
    t = (p + 67'sd32768) >>> 16;
    if (t > 67'(Q_MAX)) begin
      o.v  = Q_MAX;
      o.ov = 1'b1;
    end else if (t < 67'(Q_MIN)) begin
      o.v  = Q_MIN;
      o.ov = 1'b1;
    end else begin
      o.v  = t[31:0];
      o.ov = 1'b0;
    end
    return o;
  endfunction

  // saturate a 33-bit integer sum
  function automatic rs_t sat_wide(input logic signed [32:0] x);
    return round_sat(67'(x) <<< 16);
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

endpackage

// ===== sv/homogeneous_vector_alu.sv =====
// ---------------------------------------------------------------------------
// homogeneous_vector_alu: Q16.16 vector unit for homogeneous 4-tuples
// Four component lanes feed a merge tree (dot, magnitude), followed by a
// pipelined square root and four pipelined dividers (div, normalize).
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_ready    | in_req_type, in_a_*, in_b_*, in_scalar_in
//  out     | out_valid / out_ready  | out_r_*, out_r_scalar, out_r_flag, out_status
//  cfg     | cfg_valid / cfg_ready  | cfg_epsilon
//
//  One item per cycle while the skid register is empty; every op passes from
//  accept to out_valid through the root and the 48-stage dividers in series.
//  Synchronous active-low reset clears valids and sets epsilon to 1.
//  A full skid register freezes the whole pipeline; in_ready drops then.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
module homogeneous_vector_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_req_type,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_scalar_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_r_w,
  output logic signed [31:0] out_r_scalar,
  output logic               out_r_flag,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_epsilon
);
  import hva_pkg::*;

  localparam int NST = 1 + 6 + SQ_LAT + 1 + DIV_STEPS;

  logic               en;
  logic [NST-1:0]     pv_r;
  logic [15:0]        eps_r;

  // input stage
  logic [3:0]         op0_r;
  logic signed [31:0] a0_r [4];
  logic signed [31:0] b0_r [4];
  logic signed [31:0] s0_r;

  // lane operands and results
  logic signed [31:0] mx [4];
  logic signed [31:0] my [4];
  logic signed [31:0] mu [4];
  logic signed [31:0] mv [4];
  logic signed [63:0] p0 [4];
  rs_t                lres [4];
  rs_t                rres [4];

  // merge tree
  logic signed [64:0] q01_r, q23_r;
  logic signed [65:0] tot_r;
  rs_t                dot;

  // front contexts
  ctx_t               c1_nxt, c1_r, c2_r, c3_r, c4_nxt, c4_r, c5_r, c6_r, cin;
  logic signed [32:0] t33;
  rs_t                rs1;
  logic               eqv;

  // root pipeline
  ctx_t               dl_r [SQ_LAT];
  logic [32:0]        mag;
  ctx_t               e;

  // divider stage
  dctx_t              pr_nxt, pr_r;
  logic [32:0]        den_nxt, den_r;
  logic [47:0]        num_nxt [4];
  logic [47:0]        num_r   [4];
  logic [31:0]        abs_a   [4];
  logic [31:0]        abs_s;
  logic [47:0]        quo     [4];
  dctx_t              dd_r [DIV_STEPS];
  dctx_t              f;

  // quotient overflow per lane
  logic [3:0]         qov;
  logic               div_ov;

  // output skid
  res_t               push_d, out_d_r, skid_d_r;
  logic               push, out_v_r, skid_v_r;

  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= 16'd1;
    end else if (cfg_valid) begin
      eps_r <= cfg_epsilon;
    end
  end

  // item valids along the whole pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[NST-2:0], in_valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      op0_r   <= in_req_type;
      a0_r[0] <= in_a_x;
      a0_r[1] <= in_a_y;
      a0_r[2] <= in_a_z;
      a0_r[3] <= in_a_w;
      b0_r[0] <= in_b_x;
      b0_r[1] <= in_b_y;
      b0_r[2] <= in_b_z;
      b0_r[3] <= in_b_w;
      s0_r    <= in_scalar_in;
    end
  end

  // operand select per lane
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mx[i] = a0_r[i];
      my[i] = '0;
      mu[i] = '0;
      mv[i] = '0;
      case (op0_r) inside
        OP_SCALE:            my[i] = s0_r;
        OP_DOT, OP_REFLECT:  my[i] = b0_r[i];
        OP_MAG, OP_NORM:     my[i] = a0_r[i];
        OP_CROSS: begin
          if (i < 3) begin
            mx[i] = a0_r[(i == 2) ? 0 : i + 1];
            my[i] = b0_r[(i == 0) ? 2 : i - 1];
            mu[i] = a0_r[(i == 0) ? 2 : i - 1];
            mv[i] = b0_r[(i == 2) ? 0 : i + 1];
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    hva_lane u_lane (
      .clk  (clk),
      .en   (en),
      .x    (mx[g]),
      .y    (my[g]),
      .u    (mu[g]),
      .v    (mv[g]),
      .a_in (a0_r[g]),
      .b_in (b0_r[g]),
      .sc   ($signed(c4_r.sc)),
      .p0   (p0[g]),
      .lres (lres[g]),
      .rres (rres[g])
    );
  end

  // elementwise ops and tests
  always_comb begin
    c1_nxt    = '0;
    c1_nxt.op = op0_r;
    c1_nxt.s  = s0_r;
    t33       = '0;
    rs1       = '0;
    eqv       = 1'b1;
    for (int i = 0; i < 4; i++) c1_nxt.a[i] = a0_r[i];
    case (op0_r) inside
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int i = 0; i < 4; i++) begin
          if (op0_r == OP_ADD)      t33 = 33'(a0_r[i]) + 33'(b0_r[i]);
          else if (op0_r == OP_SUB) t33 = 33'(a0_r[i]) - 33'(b0_r[i]);
          else                      t33 = -33'(a0_r[i]);
          rs1          = sat_wide(t33);
          c1_nxt.r[i]  = rs1.v;
          c1_nxt.ov    = c1_nxt.ov | rs1.ov;
        end
      end
      OP_EQ: begin
        for (int i = 0; i < 4; i++) begin
          if (abs33(33'(a0_r[i]) - 33'(b0_r[i])) >= 33'(eps_r)) eqv = 1'b0;
        end
        c1_nxt.flag = eqv;
      end
      OP_ISPOINT: c1_nxt.flag = abs33(33'(a0_r[3]) - 33'(Q_ONE)) < 33'(eps_r);
      OP_ISVEC:   c1_nxt.flag = abs33(33'(a0_r[3])) < 33'(eps_r);
      default: ;
    endcase
  end

  // lane results and dot product
  always_comb begin
    dot       = round_sat(67'(tot_r));
    c4_nxt    = c3_r;
    c4_nxt.sq = tot_r[64:0];
    case (c3_r.op) inside
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          c4_nxt.r[i] = lres[i].v;
          c4_nxt.ov   = c4_nxt.ov | lres[i].ov;
        end
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          c4_nxt.r[i] = lres[i].v;
          c4_nxt.ov   = c4_nxt.ov | lres[i].ov;
        end
      end
      OP_DOT, OP_REFLECT: begin
        c4_nxt.sc = dot.v;
        c4_nxt.ov = dot.ov;
      end
      default: ;
    endcase
  end

  // reflect results
  always_comb begin
    cin = c6_r;
    if (c6_r.op == OP_REFLECT) begin
      for (int i = 0; i < 4; i++) begin
        cin.r[i] = rres[i].v;
        cin.ov   = cin.ov | rres[i].ov;
      end
      cin.sc = '0;
    end
  end

  // front stages and merge tree
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c1_nxt;
      c2_r  <= c1_r;
      c3_r  <= c2_r;
      c4_r  <= c4_nxt;
      c5_r  <= c4_r;
      c6_r  <= c5_r;
      q01_r <= 65'(p0[0]) + 65'(p0[1]);
      q23_r <= 65'(p0[2]) + 65'(p0[3]);
      tot_r <= 66'(q01_r) + 66'(q23_r);
    end
  end

  hva_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (cin.sq),
    .root (mag)
  );

  // context alongside the root
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= cin;
      for (int k = 1; k < SQ_LAT; k++) dl_r[k] <= dl_r[k-1];
    end
  end

  assign e = dl_r[SQ_LAT-1];

  // magnitude result and divider operands
  always_comb begin
    pr_nxt      = '0;
    pr_nxt.op   = e.op;
    pr_nxt.r    = e.r;
    pr_nxt.sc   = e.sc;
    pr_nxt.flag = e.flag;
    pr_nxt.ov   = e.ov;
    abs_s       = e.s[31] ? 32'(-e.s) : e.s;
    den_nxt     = (e.op == OP_DIV) ? {1'b0, abs_s} : mag;
    for (int i = 0; i < 4; i++) begin
      abs_a[i]      = e.a[i][31] ? 32'(-e.a[i]) : e.a[i];
      num_nxt[i]    = {abs_a[i], 16'h0000} + 48'(den_nxt[32:1]);
      pr_nxt.neg[i] = e.a[i][31] ^ ((e.op == OP_DIV) & e.s[31]);
    end
    case (e.op)
      OP_MAG: begin
        if (mag > 33'(Q_MAX)) begin
          pr_nxt.sc = Q_MAX;
          pr_nxt.ov = 1'b1;
        end else begin
          pr_nxt.sc = mag[31:0];
        end
      end
      OP_DIV, OP_NORM: pr_nxt.dz = (den_nxt == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r  <= pr_nxt;
      den_r <= den_nxt;
      for (int i = 0; i < 4; i++) num_r[i] <= num_nxt[i];
      dd_r[0] <= pr_r;
      for (int k = 1; k < DIV_STEPS; k++) dd_r[k] <= dd_r[k-1];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    hva_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[g]),
      .den (den_r),
      .quo (quo[g])
    );
  end

  assign f = dd_r[DIV_STEPS-1];

  // quotient overflow per lane
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qov[i] = f.neg[i] ? (quo[i] > 48'h0000_8000_0000) : (quo[i] > 48'(Q_MAX));
    end
    div_ov = ((f.op == OP_DIV) || (f.op == OP_NORM)) && !f.dz && (qov != 4'b0000);
  end

  // apply signs, saturate, build the result item
  always_comb begin
    push_d      = '0;
    push_d.r    = f.r;
    push_d.sc   = f.sc;
    push_d.flag = f.flag;
    push_d.status = ST_OK;
    if (((f.op == OP_DIV) || (f.op == OP_NORM)) && !f.dz) begin
      for (int i = 0; i < 4; i++) begin
        if (!f.neg[i]) begin
          if (quo[i] > 48'(Q_MAX)) begin
            push_d.r[i] = Q_MAX;
          end else begin
            push_d.r[i] = quo[i][31:0];
          end
        end else begin
          if (quo[i] > 48'h0000_8000_0000) begin
            push_d.r[i] = Q_MIN;
          end else begin
            push_d.r[i] = 32'(-quo[i][31:0]);
          end
        end
      end
    end
    if (f.dz)                 push_d.status = ST_DZ;
    else if (f.ov || div_ov)  push_d.status = ST_OVF;
  end

  assign push = pv_r[NST-1] && en;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (push) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ready) begin
      if (push) skid_d_r <= push_d;
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
    end else if (push) begin
      out_d_r <= push_d;
    end
  end

  assign out_valid    = out_v_r;
  assign out_r_x      = out_d_r.r[0];
  assign out_r_y      = out_d_r.r[1];
  assign out_r_z      = out_d_r.r[2];
  assign out_r_w      = out_d_r.r[3];
  assign out_r_scalar = out_d_r.sc;
  assign out_r_flag   = out_d_r.flag;
  assign out_status   = out_d_r.status;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status == ST_DZ) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_w == '0 &&
       out_r_scalar == '0))
    else $error("divide-by-zero result is not zero");

  a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r_flag) |-> (out_status == ST_OK))
    else $error("test flag raised with non-ok status");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r[NST-1] && !en) |=> pv_r[NST-1])
    else $error("finished item dropped during stall");

endmodule

// ===== sv/hva_lane.sv =====
// ---------------------------------------------------------------------------
// hva_lane: one component lane
// Two products per item, their difference rounded, and the reflect step
// a - 2*b*d once the merged dot product comes back.
// ---------------------------------------------------------------------------
module hva_lane (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  x,
  input  logic signed [31:0]  y,
  input  logic signed [31:0]  u,
  input  logic signed [31:0]  v,
  input  logic signed [31:0]  a_in,
  input  logic signed [31:0]  b_in,
  input  logic signed [31:0]  sc,
  output logic signed [63:0]  p0,
  output hva_pkg::rs_t        lres,
  output hva_pkg::rs_t        rres
);
  import hva_pkg::*;

  logic signed [63:0] p0_r, p1_r, m_r;
  logic signed [66:0] lsum_r;
  rs_t                lres_r, rres_r;
  logic signed [31:0] a1_r, a2_r, a3_r, a4_r, a5_r;
  logic signed [31:0] b1_r, b2_r, b3_r, b4_r;
  logic signed [63:0] p0_nxt, p1_nxt, m_nxt;
  logic signed [66:0] rp;

  // products
  always_comb begin
    p0_nxt = x * y;
    p1_nxt = u * v;
    m_nxt  = b4_r * sc;
    rp     = (67'(a5_r) <<< 16) - (67'(m_r) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      lsum_r <= 67'(p0_r) - 67'(p1_r);
      lres_r <= round_sat(lsum_r);
      a1_r   <= a_in;
      a2_r   <= a1_r;
      a3_r   <= a2_r;
      a4_r   <= a3_r;
      a5_r   <= a4_r;
      b1_r   <= b_in;
      b2_r   <= b1_r;
      b3_r   <= b2_r;
      b4_r   <= b3_r;
      m_r    <= m_nxt;
      rres_r <= round_sat(rp);
    end
  end

  assign p0   = p0_r;
  assign lres = lres_r;
  assign rres = rres_r;

endmodule

// ===== sv/hva_sqrt.sv =====
// ---------------------------------------------------------------------------
// hva_sqrt: pipelined square root
// One root bit per stage, then round to nearest from the final remainder.
// ---------------------------------------------------------------------------
module hva_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [64:0] rad,
  output logic [32:0] root
);
  import hva_pkg::*;

  localparam int RW = 36;

  logic [RW-1:0] rem_r   [SQ_STEPS];
  logic [32:0]   rt_r    [SQ_STEPS];
  logic [65:0]   rd_r    [SQ_STEPS];
  logic [RW-1:0] rem_in  [SQ_STEPS];
  logic [32:0]   rt_in   [SQ_STEPS];
  logic [65:0]   rd_in   [SQ_STEPS];
  logic [RW+1:0] cur     [SQ_STEPS];
  logic [RW+1:0] trial   [SQ_STEPS];
  logic [RW+1:0] diff    [SQ_STEPS];
  logic          ge      [SQ_STEPS];
  logic [RW-1:0] rem_nxt [SQ_STEPS];
  logic [32:0]   rt_nxt  [SQ_STEPS];
  logic [65:0]   rd_nxt  [SQ_STEPS];
  logic [32:0]   root_r;

  // stage inputs and one digit step per stage
  always_comb begin
    rem_in[0] = '0;
    rt_in[0]  = '0;
    rd_in[0]  = {1'b0, rad};
    for (int k = 1; k < SQ_STEPS; k++) begin
      rem_in[k] = rem_r[k-1];
      rt_in[k]  = rt_r[k-1];
      rd_in[k]  = rd_r[k-1];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      cur[k]     = {rem_in[k], rd_in[k][65:64]};
      trial[k]   = {3'b000, rt_in[k], 2'b01};
      diff[k]    = cur[k] - trial[k];
      ge[k]      = cur[k] >= trial[k];
      rem_nxt[k] = ge[k] ? diff[k][RW-1:0] : cur[k][RW-1:0];
      rt_nxt[k]  = {rt_in[k][31:0], ge[k]};
      rd_nxt[k]  = {rd_in[k][63:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        rt_r[k]  <= rt_nxt[k];
        rd_r[k]  <= rd_nxt[k];
      end
      // round up when remainder exceeds the root
      root_r <= (rem_r[SQ_STEPS-1] > RW'(rt_r[SQ_STEPS-1])) ?
                rt_r[SQ_STEPS-1] + 33'd1 : rt_r[SQ_STEPS-1];
    end
  end

  assign root = root_r;

endmodule

// ===== sv/hva_div.sv =====
// ---------------------------------------------------------------------------
// hva_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, 48-bit dividend.
// ---------------------------------------------------------------------------
module hva_div (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] num,
  input  logic [32:0] den,
  output logic [47:0] quo
);
  import hva_pkg::*;

  logic [32:0] rem_r   [DIV_STEPS];
  logic [47:0] sh_r    [DIV_STEPS];
  logic [32:0] d_r     [DIV_STEPS];
  logic [32:0] rem_in  [DIV_STEPS];
  logic [47:0] sh_in   [DIV_STEPS];
  logic [32:0] d_in    [DIV_STEPS];
  logic [33:0] cur     [DIV_STEPS];
  logic [33:0] diff    [DIV_STEPS];
  logic        ge      [DIV_STEPS];
  logic [32:0] rem_nxt [DIV_STEPS];
  logic [47:0] sh_nxt  [DIV_STEPS];

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    rem_in[0] = '0;
    sh_in[0]  = num;
    d_in[0]   = den;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_in[k] = rem_r[k-1];
      sh_in[k]  = sh_r[k-1];
      d_in[k]   = d_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      cur[k]     = {rem_in[k], sh_in[k][47]};
      diff[k]    = cur[k] - {1'b0, d_in[k]};
      ge[k]      = cur[k] >= {1'b0, d_in[k]};
      rem_nxt[k] = ge[k] ? diff[k][32:0] : cur[k][32:0];
      sh_nxt[k]  = {sh_in[k][46:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        sh_r[k]  <= sh_nxt[k];
        d_r[k]   <= d_in[k];
      end
    end
  end

  assign quo = sh_r[DIV_STEPS-1];

endmodule
